/* design/kmp_pkg.sv */
// kmp_pkg: shared types and constants of the streaming KMP matcher
// used by the channel interfaces, the matcher cell and the top level
`default_nettype none

package kmp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 32;

  // item function codes
  typedef enum logic [1:0] {
    FUNC_NEW     = 2'd0,
    FUNC_APPEND  = 2'd1,
    FUNC_TEXT    = 2'd2,
    FUNC_RESTART = 2'd3
  } func_t;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic              load;   // write data into the cell at the write index
    logic              clear;  // drop all partial matches
    logic              flush;  // drop partial matches before this step
    logic              step;   // advance partial matches by one text byte
    logic [BYTE_W-1:0] data;   // pattern or text byte
  } cell_ctl_t;

endpackage

`default_nettype wire

/* design/kmp_if.sv */
// kmp_if: valid/ready channel interfaces for items and results
// depends on kmp_pkg for field widths
`default_nettype none

interface kmp_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                func;
  logic [kmp_pkg::BYTE_W-1:0] data_byte;
  logic                      last_text;

  modport source (output valid, output func, output data_byte, output last_text,
                  input ready);
  modport sink   (input valid, input func, input data_byte, input last_text,
                  output ready);
endinterface

interface kmp_out_if;
  logic                      valid;
  logic                      ready;
  logic                      match;
  logic [kmp_pkg::POS_W-1:0] match_start;
  logic                      found_any;
  logic                      pattern_full;
  logic                      text_done;

  modport source (output valid, output match, output match_start, output found_any,
                  output pattern_full, output text_done, input ready);
  modport sink   (input valid, input match, input match_start, input found_any,
                  input pattern_full, input text_done, output ready);
endinterface

`default_nettype wire

/* design/kmp_cell.sv */
// kmp_cell: one pattern position of the matcher chain
// holds one pattern byte and one partial-match bit; depends on kmp_pkg
`default_nettype none

module kmp_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned LEN_W    = 6
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire kmp_pkg::cell_ctl_t ctl,
  input  wire logic [LEN_W-1:0]   wr_len,   // index written by a pattern byte
  input  wire logic [LEN_W-1:0]   len,      // current pattern length
  input  wire logic               prev_act, // partial match of the left neighbor
  output logic                    act,      // partial match held in this cell
  output logic                    hit       // full match completes in this cell
);

  localparam logic [LEN_W-1:0] MyIdx  = LEN_W'(CELL_IDX);
  localparam logic [LEN_W-1:0] MyNext = LEN_W'(CELL_IDX + 1);

  logic [kmp_pkg::BYTE_W-1:0] byte_r;
  logic                       act_r;
  logic                       act_nxt;
  logic                       prev_ok;

  // pattern byte store
  always_ff @(posedge clk) begin
    if (ctl.load && (wr_len == MyIdx)) begin
      byte_r <= ctl.data;
    end
  end

  // the first cell can always start a new partial match, with no left neighbor
  assign prev_ok = (CELL_IDX == 0) ? 1'b1 : (prev_act & ~ctl.flush);

  // extend the neighbor's partial match by one byte
  always_comb begin
    act_nxt = prev_ok && (byte_r == ctl.data) && (len > MyIdx);
  end

  // partial match bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else if (ctl.clear) begin
      act_r <= 1'b0;
    end else if (ctl.step) begin
      act_r <= act_nxt;
    end
  end

  assign act = act_r;
  assign hit = ctl.step && act_nxt && (len == MyNext);

endmodule

`default_nettype wire

/* design/kmp_stream_matcher_unit.sv */
// kmp_stream_matcher_unit: streaming pattern matcher, top level
// depends on kmp_pkg, kmp_in_if / kmp_out_if and a chain of kmp_cell
//
//   channel | dir | handshake        | payload
//   in_ch   | in  | valid / ready    | func, data_byte, last_text
//   out_ch  | out | valid / ready    | match, match_start, found_any,
//           |     |                  | pattern_full, text_done
//
// one item per cycle while the output side takes results: every cell compares
// the broadcast byte with its own pattern byte in the same cycle and hands its
// partial-match bit to the next cell; the result is registered on transfer
// reset (rst_n low, synchronous) empties the pattern, clears all partial
// matches, the text position and the found flag; pattern bytes hold no reset
// the output register frees the input side: a new item is taken whenever the
// output register is empty or its result is taken in the same cycle
`default_nettype none

module kmp_stream_matcher_unit #(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  kmp_in_if.sink     in_ch,
  kmp_out_if.source  out_ch
);

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_PATTERN);
  localparam int unsigned POS_W = kmp_pkg::POS_W;

  kmp_pkg::func_t     func;
  kmp_pkg::cell_ctl_t ctl;

  logic                   in_xfer;
  logic                   is_pattern;
  logic                   is_restart;
  logic                   full;
  logic                   hit;
  logic [LEN_W-1:0]       wr_len;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [POS_W-1:0]       pos_cur;
  logic                   any_r, any_nxt;
  logic [POS_W-1:0]       start;
  logic [MAX_PATTERN-1:0] act_vec;
  logic [MAX_PATTERN-1:0] hit_vec;

  logic                   out_valid_r;
  logic                   out_match_r;
  logic [POS_W-1:0]       out_start_r;
  logic                   out_found_r;
  logic                   out_full_r;
  logic                   out_done_r;

  // input handshake
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign func        = kmp_pkg::func_t'(in_ch.func);

  // item decode
  always_comb begin
    is_pattern = 1'b0;
    is_restart = 1'b0;
    wr_len     = len_r;
    unique case (func)
      kmp_pkg::FUNC_NEW: begin
        is_pattern = 1'b1;
        wr_len     = '0;
      end
      kmp_pkg::FUNC_APPEND: begin
        is_pattern = 1'b1;
      end
      kmp_pkg::FUNC_TEXT: begin
      end
      kmp_pkg::FUNC_RESTART: begin
        is_restart = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign full = is_pattern && (wr_len >= MaxLen);

  // control broadcast to the cell chain
  always_comb begin
    ctl.load  = in_xfer && is_pattern && !full;
    ctl.clear = in_xfer && is_pattern && !full;
    ctl.flush = is_restart;
    ctl.step  = in_xfer && !is_pattern;
    ctl.data  = in_ch.data_byte;
  end

  // chain of cells, partial matches move one cell per text byte
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    kmp_cell #(
      .CELL_IDX (i),
      .LEN_W    (LEN_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .wr_len   (wr_len),
      .len      (len_r),
      .prev_act ((i == 0) ? 1'b1 : act_vec[(i == 0) ? 0 : i - 1]),
      .act      (act_vec[i]),
      .hit      (hit_vec[i])
    );
  end

  assign hit = |hit_vec;

  // text position, start index and found flag
  always_comb begin
    pos_cur = is_restart ? '0 : pos_r;
    start   = pos_cur - POS_W'(len_r) + POS_W'(1);
    len_nxt = len_r;
    pos_nxt = pos_r;
    any_nxt = any_r;
    if (is_pattern) begin
      if (!full) begin
        len_nxt = wr_len + LEN_W'(1);
      end
    end else begin
      pos_nxt = (pos_cur == {POS_W{1'b1}}) ? pos_cur : pos_cur + POS_W'(1);
      any_nxt = (is_restart ? 1'b0 : any_r) | hit;
    end
  end

  // matcher state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      pos_r <= '0;
      any_r <= 1'b0;
    end else if (in_xfer) begin
      len_r <= len_nxt;
      pos_r <= pos_nxt;
      any_r <= any_nxt;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_match_r <= hit;
      out_start_r <= hit ? start : '0;
      out_found_r <= any_nxt;
      out_full_r  <= full;
      out_done_r  <= !is_pattern && in_ch.last_text;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.match        = out_match_r;
  assign out_ch.match_start  = out_start_r;
  assign out_ch.found_any    = out_found_r;
  assign out_ch.pattern_full = out_full_r;
  assign out_ch.text_done    = out_done_r;

  // a reported match always raises the found flag
  a_match_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_match_r |-> out_found_r)
    else $error("match reported without found flag");

  // a dropped pattern byte never reports text completion or a match
  a_full_no_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_full_r |-> !out_done_r && !out_match_r)
    else $error("dropped pattern byte flagged as text");

  // a stored pattern byte leaves a non-empty pattern
  a_len_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> len_r != '0)
    else $error("pattern length empty after store");

  // pattern length stays within the cell chain
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= MaxLen)
    else $error("pattern length beyond cell chain");

  // no partial match outlives a stored pattern byte
  a_clear_act: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> act_vec == '0)
    else $error("partial match kept across pattern change");

endmodule

`default_nettype wire
